// ===== rtl/f2h_pkg.sv =====
`default_nettype none
package f2h_pkg;
   localparam int unsigned SingleWidth = 32;
   localparam int unsigned HalfWidth = 16;
   localparam logic [14:0] HalfQnan = 15'h7e00;
   localparam logic [14:0] HalfMaxFin = 15'h7bff;
   localparam logic [14:0] HalfInf = 15'h7c00;
   localparam logic [30:0] SingleExpMask = 31'h7f800000;
   localparam logic [12:0] Low13Half = 13'h1000;
endpackage
`default_nettype wire

// ===== rtl/f2h_if.sv =====
`default_nettype none
interface f2h_if #(parameter int unsigned Width = 32);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/f2h_convert.sv =====
`default_nettype none
module f2h_convert
   import f2h_pkg::*;
(
   input  wire logic [SingleWidth-1:0] single_bits,
   output logic [HalfWidth-1:0]        half_bits
);
   logic        sign;
   logic [30:0] mag;
   logic [7:0]  exp_s;
   logic [23:0] mant;
   logic [4:0]  shift;
   logic [23:0] sub_q;
   logic [23:0] sub_rem;
   logic [23:0] sub_half;
   logic [14:0] sub_res;
   logic [14:0] norm_h;
   logic [14:0] norm_r;
   logic [12:0] rem13;

   always_comb begin
      sign = single_bits[31];
      mag = single_bits[30:0];
      exp_s = single_bits[30:23];
      mant = {1'b1, single_bits[22:0]};
      shift = 5'(8'd126 - exp_s);
      sub_q = mant >> shift;
      sub_rem = mant & ((24'd1 << shift) - 24'd1);
      sub_half = 24'd1 << (shift - 5'd1);
      sub_res = sub_q[14:0];
      if (sub_rem > sub_half || (sub_rem == sub_half && sub_q[0])) begin
         sub_res = 15'(sub_q + 24'd1);
      end
      norm_h = {5'(exp_s - 8'd112), single_bits[22:13]};
      rem13 = single_bits[12:0];
      norm_r = norm_h;
      if (rem13 > Low13Half || (rem13 == Low13Half && norm_h[0])) begin
         norm_r = norm_h + 15'd1;
      end
      if (norm_r >= HalfInf) begin
         norm_r = HalfMaxFin;
      end
      if (mag > SingleExpMask) begin
         half_bits = {sign, HalfQnan};
      end else if (exp_s >= 8'd143) begin
         half_bits = {sign, HalfMaxFin};
      end else if (exp_s < 8'd102) begin
         half_bits = {sign, 15'd0};
      end else if (exp_s <= 8'd112) begin
         half_bits = {sign, sub_res};
      end else begin
         half_bits = {sign, norm_r};
      end
   end
endmodule
`default_nettype wire

// ===== rtl/float32_to_half_saturating.sv =====
// path: an accepted input item enters the input register, is converted combinationally, then enters the result register
// throughput: one item per cycle while rsp.ready does not stall the result register; the conversion is combinational
// an input register and a result register with skid-free backpressure
// reset: synchronous active-high reset empties both registers
`default_nettype none
module float32_to_half_saturating
   import f2h_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   f2h_if.sink      req,
   f2h_if.source    rsp
);
   logic                   in_valid_ff, in_valid_in;
   logic [SingleWidth-1:0] in_data_ff, in_data_in;
   logic                   out_valid_ff, out_valid_in;
   logic [HalfWidth-1:0]   out_data_ff, out_data_in;
   logic [HalfWidth-1:0]   conv;
   logic                   out_take, in_take;

   f2h_convert u_conv (.single_bits(in_data_ff), .half_bits(conv));

   always_comb begin
      out_take = !out_valid_ff || rsp.ready;
      in_take = !in_valid_ff || out_take;
      req.ready = in_take;
      rsp.valid = out_valid_ff;
      rsp.data = out_data_ff;
      in_valid_in = in_valid_ff;
      in_data_in = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      if (out_take) begin
         out_valid_in = in_valid_ff;
         out_data_in = conv;
      end
      if (in_take) begin
         in_valid_in = req.valid;
         in_data_in = req.data;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      out_data_ff <= out_data_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("result item changed under stall");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_take |=> in_valid_ff && $stable(in_data_ff))
      else $error("input item lost");
   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_take |=> out_valid_ff)
      else $error("item not advanced");
endmodule
`default_nettype wire
